// ===== rtl/core/trsj_pkg.sv =====
// package for the thread scheduler: slot states, request kinds, outcome codes
// no dependencies
package trsj_pkg;
   localparam int SLOT_COUNT_DEF = 16;
   localparam int ID_BITS_DEF = 32;
   localparam int TIME_BITS = 64;
   localparam int ID_W = 32;

   typedef enum logic [2:0] {
      ST_UNUSED = 3'd0, ST_READY = 3'd1, ST_RUNNING = 3'd2,
      ST_JOINED = 3'd3, ST_SLEEPING = 3'd4
   } slot_state_type;

   localparam logic [2:0] K_CREATE = 3'd0;
   localparam logic [2:0] K_YIELD = 3'd1;
   localparam logic [2:0] K_JOIN = 3'd2;
   localparam logic [2:0] K_SLEEP = 3'd3;
   localparam logic [2:0] K_EXIT = 3'd4;
   localparam logic [2:0] K_TICK = 3'd5;

   localparam logic [1:0] OC_OK = 2'd0;
   localparam logic [1:0] OC_NOFREE = 2'd1;
   localparam logic [1:0] OC_NOTARGET = 2'd2;
   localparam logic [1:0] OC_NORUN = 2'd3;

   typedef enum logic [3:0] {
      FS_IDLE, FS_SCAN, FS_DECIDE, FS_WALK, FS_HEAD, FS_OUT
   } fsm_state_type;

   // controller to datapath
   typedef struct packed {
      logic start;      // latch request, clear scan
      logic scan_step;  // examine one slot
      logic decide;     // apply create / yield / join / sleep / exit / tick work
      logic walk_init;  // set up list walk
      logic walk_step;  // one node of the list walk
      logic run_head;   // dequeue head when required
      logic finish;     // build result item
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic need_walk;
      logic walk_done;
   } status_type;
endpackage

// ===== rtl/core/thread_ready_sleep_join_scheduler.sv =====
// top level of the thread scheduler: controller plus datapath
// depends on trsj_pkg, trsj_ctrl, trsj_dp
// each item runs a slot scan, a decide step, an optional list walk and a head step
// throughput: one item at a time; a new request is taken only after the response
// is accepted, with a one-slot-per-cycle scan and a one-node-per-cycle list walk
// reset: synchronous, slot 0 running with id 0, all lists empty
module thread_ready_sleep_join_scheduler #(
   parameter int SLOT_COUNT = trsj_pkg::SLOT_COUNT_DEF,
   parameter int ID_BITS = trsj_pkg::ID_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [2:0] kind, [34:3] target_id, [98:35] time_value, [103:99] zero
   input  logic [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] running_id, [32] running_valid, [64:33] new_id, [65] switched,
   // [67:66] outcome, [71:68] zero
   output logic [71:0]  rsp_tdata
);
   import trsj_pkg::*;
   cmd_type    cmd;
   status_type stat;
   logic [ID_W-1:0] running_id, new_id;
   logic running_valid, switched;
   logic [1:0] outcome;

   // control sequencer
   trsj_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .cmd(cmd), .stat(stat)
   );

   // slot table and list datapath
   trsj_dp #(.SLOT_COUNT(SLOT_COUNT), .ID_BITS(ID_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .kind(req_tdata[2:0]), .target_id(req_tdata[34:3]),
      .time_value(req_tdata[98:35]),
      .running_id(running_id), .running_valid(running_valid),
      .new_id(new_id), .switched(switched), .outcome(outcome)
   );

   assign rsp_tdata = {4'b0, outcome, switched, new_id, running_valid, running_id};
endmodule

// ===== rtl/core/trsj_ctrl.sv =====
// controller state machine for the thread scheduler
// depends on trsj_pkg
module trsj_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output trsj_pkg::cmd_type   cmd,
   input  trsj_pkg::status_type stat
);
   import trsj_pkg::*;
   fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         FS_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in = FS_SCAN;
            end
         end
         FS_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) state_in = FS_DECIDE;
         end
         FS_DECIDE: begin
            cmd.decide = 1'b1;
            if (stat.need_walk) begin
               cmd.walk_init = 1'b1;
               state_in = FS_WALK;
            end else begin
               state_in = FS_HEAD;
            end
         end
         FS_WALK: begin
            cmd.walk_step = 1'b1;
            if (stat.walk_done) state_in = FS_HEAD;
         end
         FS_HEAD: begin
            cmd.run_head = 1'b1;
            cmd.finish = 1'b1;
            state_in = FS_OUT;
         end
         FS_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) state_in = FS_IDLE;
         end
         default: state_in = FS_IDLE;
      endcase
   end
endmodule

// ===== rtl/core/trsj_dp.sv =====
// datapath for the thread scheduler: slot table, lists, scans and list walks
// depends on trsj_pkg
module trsj_dp #(
   parameter int SLOT_COUNT = trsj_pkg::SLOT_COUNT_DEF,
   parameter int ID_BITS = trsj_pkg::ID_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  trsj_pkg::cmd_type          cmd,
   output trsj_pkg::status_type       stat,
   input  logic [2:0]                 kind,
   input  logic [trsj_pkg::ID_W-1:0]  target_id,
   input  logic [trsj_pkg::TIME_BITS-1:0] time_value,
   output logic [trsj_pkg::ID_W-1:0]  running_id,
   output logic                       running_valid,
   output logic [trsj_pkg::ID_W-1:0]  new_id,
   output logic                       switched,
   output logic [1:0]                 outcome
);
   import trsj_pkg::*;
   localparam int SW = $clog2(SLOT_COUNT + 1);
   localparam int IW = $clog2(SLOT_COUNT);
   localparam logic [SW-1:0] NIL = SW'(SLOT_COUNT);
   localparam logic [SW-1:0] LAST = SW'(SLOT_COUNT - 1);

   slot_state_type     st_ff [SLOT_COUNT];
   logic [ID_BITS-1:0] tid_ff [SLOT_COUNT];
   logic [TIME_BITS-1:0] wake_ff [SLOT_COUNT];
   logic [ID_BITS-1:0] jt_ff [SLOT_COUNT];
   logic [SW-1:0]      link_ff [SLOT_COUNT];
   logic [SW-1:0]      rfirst_ff, rlast_ff, jfirst_ff, sfirst_ff, cur_ff, old_ff;
   logic [ID_BITS-1:0] last_id_ff;

   logic [2:0]         kind_ff;
   logic [ID_BITS-1:0] tgt_ff;
   logic [TIME_BITS-1:0] tval_ff;
   logic [SW-1:0]      scan_ff, free_ff, found_ff;
   logic               idle_ff, want_head_ff;
   logic [ID_BITS-1:0] newid_ff, key_ff;
   logic [1:0]         oc_ff;
   logic               walk_sleep_ff;
   logic [SW-1:0]      wcur_ff, wprev_ff, guard_ff;
   logic [ID_W-1:0]    run_id_ff, new_id_o_ff;
   logic               run_v_ff, sw_ff;
   logic [1:0]         oc_o_ff;

   logic [IW-1:0] si, ci, wi, pi, rl, rf;
   logic hit;
   logic [SW-1:0] nxt;
   assign si = scan_ff[IW-1:0];
   assign ci = cur_ff[IW-1:0];
   assign wi = wcur_ff[IW-1:0];
   assign pi = wprev_ff[IW-1:0];
   assign rl = rlast_ff[IW-1:0];
   assign rf = rfirst_ff[IW-1:0];
   assign nxt = link_ff[wi];
   assign hit = walk_sleep_ff ? (wake_ff[wi] <= tval_ff) : (jt_ff[wi] == key_ff);

   assign stat.scan_done = (scan_ff == LAST);
   assign stat.need_walk = (kind_ff == K_TICK) ||
                           (kind_ff == K_EXIT && !idle_ff);
   assign stat.walk_done = (wcur_ff >= NIL) || (guard_ff >= NIL) ||
                           ((nxt >= NIL || guard_ff == LAST) && 1'b1 &&
                            (wcur_ff < NIL));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            st_ff[i] <= (i == 0) ? ST_RUNNING : ST_UNUSED;
            tid_ff[i] <= '0;
            wake_ff[i] <= '0;
            jt_ff[i] <= '0;
            link_ff[i] <= NIL;
         end
         rfirst_ff <= NIL; rlast_ff <= NIL; jfirst_ff <= NIL; sfirst_ff <= NIL;
         cur_ff <= '0; old_ff <= '0; last_id_ff <= '0;
         scan_ff <= '0; free_ff <= NIL; found_ff <= NIL;
         idle_ff <= 1'b0; want_head_ff <= 1'b0; walk_sleep_ff <= 1'b0;
         wcur_ff <= NIL; wprev_ff <= NIL; guard_ff <= '0;
      end else begin
         if (cmd.start) begin
            kind_ff <= kind;
            tgt_ff <= target_id[ID_BITS-1:0];
            tval_ff <= time_value;
            scan_ff <= '0;
            free_ff <= NIL;
            found_ff <= NIL;
            idle_ff <= (cur_ff >= NIL);
            old_ff <= cur_ff;
            want_head_ff <= 1'b0;
            newid_ff <= '0;
            oc_ff <= OC_OK;
         end
         // one slot per cycle: lowest free slot and first live id match
         if (cmd.scan_step) begin
            if (free_ff == NIL && st_ff[si] == ST_UNUSED) free_ff <= scan_ff;
            if (found_ff == NIL && st_ff[si] != ST_UNUSED && tid_ff[si] == tgt_ff)
               found_ff <= scan_ff;
            if (scan_ff != LAST) scan_ff <= scan_ff + 1'b1;
         end
         if (cmd.decide) begin
            case (kind_ff)
               K_CREATE: begin
                  if (free_ff == NIL) begin
                     oc_ff <= OC_NOFREE;
                  end else begin
                     last_id_ff <= last_id_ff + 1'b1;
                     newid_ff <= last_id_ff + 1'b1;
                     tid_ff[free_ff[IW-1:0]] <= last_id_ff + 1'b1;
                     jt_ff[free_ff[IW-1:0]] <= '0;
                     wake_ff[free_ff[IW-1:0]] <= '0;
                     st_ff[free_ff[IW-1:0]] <= ST_READY;
                     link_ff[free_ff[IW-1:0]] <= NIL;
                     if (rlast_ff >= NIL) rfirst_ff <= free_ff;
                     else link_ff[rl] <= free_ff;
                     rlast_ff <= free_ff;
                  end
                  want_head_ff <= idle_ff;
               end
               K_TICK: want_head_ff <= idle_ff;
               K_YIELD: begin
                  if (idle_ff) begin
                     if (rfirst_ff >= NIL) oc_ff <= OC_NORUN;
                  end else begin
                     st_ff[ci] <= ST_READY;
                     link_ff[ci] <= NIL;
                     if (rlast_ff >= NIL) rfirst_ff <= cur_ff;
                     else link_ff[rl] <= cur_ff;
                     rlast_ff <= cur_ff;
                  end
                  want_head_ff <= 1'b1;
               end
               K_JOIN: begin
                  if (idle_ff) oc_ff <= OC_NORUN;
                  else if (found_ff == NIL) oc_ff <= OC_NOTARGET;
                  else begin
                     jt_ff[ci] <= tgt_ff;
                     st_ff[ci] <= ST_JOINED;
                     link_ff[ci] <= jfirst_ff;
                     jfirst_ff <= cur_ff;
                     want_head_ff <= 1'b1;
                  end
               end
               K_SLEEP: begin
                  if (idle_ff) oc_ff <= OC_NORUN;
                  else begin
                     wake_ff[ci] <= tval_ff;
                     st_ff[ci] <= ST_SLEEPING;
                     link_ff[ci] <= sfirst_ff;
                     sfirst_ff <= cur_ff;
                     want_head_ff <= 1'b1;
                  end
               end
               K_EXIT: begin
                  if (idle_ff) oc_ff <= OC_NORUN;
                  else begin
                     st_ff[ci] <= ST_UNUSED;
                     link_ff[ci] <= NIL;
                     want_head_ff <= 1'b1;
                  end
               end
               default: ;
            endcase
         end
         if (cmd.walk_init) begin
            walk_sleep_ff <= (kind_ff == K_TICK);
            key_ff <= tid_ff[ci];
            wcur_ff <= (kind_ff == K_TICK) ? sfirst_ff : jfirst_ff;
            wprev_ff <= NIL;
            guard_ff <= '0;
         end
         // one list node per cycle; a hit is unlinked and appended to ready
         if (cmd.walk_step && wcur_ff < NIL && guard_ff < NIL) begin
            if (hit) begin
               if (wprev_ff < NIL) link_ff[pi] <= nxt;
               else if (walk_sleep_ff) sfirst_ff <= nxt;
               else jfirst_ff <= nxt;
               st_ff[wi] <= ST_READY;
               link_ff[wi] <= NIL;
               if (rlast_ff >= NIL) rfirst_ff <= wcur_ff;
               else link_ff[rl] <= wcur_ff;
               rlast_ff <= wcur_ff;
            end else begin
               wprev_ff <= wcur_ff;
            end
            wcur_ff <= nxt;
            guard_ff <= guard_ff + 1'b1;
         end
         if (cmd.run_head && want_head_ff) begin
            cur_ff <= rfirst_ff;
            if (rfirst_ff < NIL) begin
               st_ff[rf] <= ST_RUNNING;
               link_ff[rf] <= NIL;
               if (rlast_ff == rfirst_ff) begin
                  rfirst_ff <= NIL; rlast_ff <= NIL;
               end else begin
                  rfirst_ff <= link_ff[rf];
               end
            end
         end
      end
   end

   // result item, built from the state left after run_head
   logic [SW-1:0] cur_next;
   assign cur_next = (want_head_ff) ? rfirst_ff : cur_ff;
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (cur_next < NIL) begin
            run_id_ff <= ID_W'(tid_ff[cur_next[IW-1:0]]);
            run_v_ff <= 1'b1;
         end else begin
            run_id_ff <= '0;
            run_v_ff <= 1'b0;
         end
         new_id_o_ff <= ID_W'(newid_ff);
         sw_ff <= (cur_next != old_ff);
         oc_o_ff <= oc_ff;
      end
   end
   assign running_id = run_id_ff;
   assign running_valid = run_v_ff;
   assign new_id = new_id_o_ff;
   assign switched = sw_ff;
   assign outcome = oc_o_ff;
endmodule
